// ===== hdl/f2dt_pkg.sv =====
// ----------------------------------------------------------------------------
// f2dt_pkg
// Types, character codes and helpers shared by the fixed-point to decimal
// text formatter.
// ----------------------------------------------------------------------------
package f2dt_pkg;

    localparam int INT_DIGITS      = 5;
    localparam int MAX_FRAC_DIGITS = 4;
    localparam int FVAL_W          = 14;

    localparam logic [31:0] DIV10_MUL = 32'd52429;

    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_COMMA = 7'h2C;
    localparam logic [6:0] CH_DOT   = 7'h2E;
    localparam logic [6:0] CH_ZERO  = 7'h30;

    typedef logic [3:0] bcd_t;

    typedef struct packed {
        logic                              neg;
        bcd_t [INT_DIGITS-1:0]             int_dig;
        logic [2:0]                        int_cnt;
        bcd_t [MAX_FRAC_DIGITS-1:0]        frac_dig;
        logic                              frac_zero;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CONV,
        FR_HOLD
    } fr_state_t;

    typedef enum logic [1:0] {
        PH_SIGN,
        PH_INT,
        PH_SEP,
        PH_FRAC
    } phase_t;

    // Quotient by ten through a reciprocal multiply; exact for all 16-bit inputs.
    function automatic logic [15:0] div10(input logic [15:0] x);
        logic [31:0] p;
        p = {16'd0, x} * DIV10_MUL;
        return {3'd0, p[31:19]};
    endfunction

    function automatic bcd_t mod10(input logic [15:0] x, input logic [15:0] q);
        logic [15:0] r;
        r = x - ((q << 3) + (q << 1));
        return r[3:0];
    endfunction

endpackage

// ===== hdl/f2dt_front.sv =====
// ----------------------------------------------------------------------------
// f2dt_front
// Accepts a value, scales its fraction and splits both parts into decimal
// digits, one digit of each per cycle, then hands the result to the queue.
// ----------------------------------------------------------------------------
module f2dt_front #(
    parameter int FRACTION_DIGITS = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_is_negative,
    input  logic [15:0]          s_integer_part,
    input  logic [15:0]          s_fraction_part,
    input  f2dt_pkg::q_status_t  q_status,
    output logic                 push,
    output f2dt_pkg::entry_t     push_data
);

    localparam int FRAC_SCALE = 10 ** FRACTION_DIGITS;
    localparam int LAST_STEP  = f2dt_pkg::INT_DIGITS - 1;

    f2dt_pkg::fr_state_t state_reg, state_next;
    logic [2:0]  k_reg, k_next;
    logic [15:0] iv_reg;
    logic [f2dt_pkg::FVAL_W-1:0] fv_reg;
    f2dt_pkg::entry_t ent_reg;

    logic        accept;
    logic [29:0] fprod;
    logic [f2dt_pkg::FVAL_W-1:0] fval;
    logic [15:0] iq, fq;
    f2dt_pkg::bcd_t id, fd;

    assign accept = s_valid && s_ready;
    assign fprod  = 30'(s_fraction_part) * 30'(FRAC_SCALE);
    assign fval   = fprod[29:16];
    assign iq     = f2dt_pkg::div10(iv_reg);
    assign id     = f2dt_pkg::mod10(iv_reg, iq);
    assign fq     = f2dt_pkg::div10(16'(fv_reg));
    assign fd     = f2dt_pkg::mod10(16'(fv_reg), fq);
    assign push_data = ent_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            f2dt_pkg::FR_IDLE: begin
                if (accept) state_next = f2dt_pkg::FR_CONV;
            end
            f2dt_pkg::FR_CONV: begin
                if (k_reg == 3'(LAST_STEP)) state_next = f2dt_pkg::FR_HOLD;
            end
            f2dt_pkg::FR_HOLD: begin
                if (!q_status.full) begin
                    state_next = accept ? f2dt_pkg::FR_CONV : f2dt_pkg::FR_IDLE;
                end
            end
            default: state_next = f2dt_pkg::FR_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        push    = 1'b0;
        unique case (state_reg)
            f2dt_pkg::FR_IDLE: s_ready = 1'b1;
            f2dt_pkg::FR_CONV: s_ready = 1'b0;
            f2dt_pkg::FR_HOLD: begin
                s_ready = !q_status.full;
                push    = !q_status.full;
            end
            default: s_ready = 1'b0;
        endcase
    end

    always_comb begin
        k_next = k_reg;
        if (accept) begin
            k_next = 3'd0;
        end else if (state_reg == f2dt_pkg::FR_CONV) begin
            k_next = k_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= f2dt_pkg::FR_IDLE;
            k_reg     <= 3'd0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            iv_reg            <= s_integer_part;
            fv_reg            <= fval;
            ent_reg.neg       <= s_is_negative &&
                                 (s_integer_part != 16'd0 || s_fraction_part != 16'd0);
            ent_reg.frac_zero <= (fval == '0);
            ent_reg.int_cnt   <= 3'd1;
        end else if (state_reg == f2dt_pkg::FR_CONV) begin
            iv_reg <= iq;
            fv_reg <= fq[f2dt_pkg::FVAL_W-1:0];
            for (int i = 0; i < f2dt_pkg::INT_DIGITS; i++) begin
                if (k_reg == 3'(i)) begin
                    ent_reg.int_dig[i] <= id;
                    if (i == 0 || iv_reg != 16'd0) ent_reg.int_cnt <= 3'(i + 1);
                end
            end
            for (int i = 0; i < f2dt_pkg::MAX_FRAC_DIGITS; i++) begin
                if (i < FRACTION_DIGITS && k_reg == 3'(i)) ent_reg.frac_dig[i] <= fd;
            end
        end
    end

endmodule

// ===== hdl/f2dt_queue.sv =====
// ----------------------------------------------------------------------------
// f2dt_queue
// Two-entry queue of converted values between the front and back parts.
// ----------------------------------------------------------------------------
module f2dt_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  f2dt_pkg::entry_t     push_data,
    input  logic                 pop,
    output f2dt_pkg::entry_t     head,
    output f2dt_pkg::q_status_t  status
);

    f2dt_pkg::entry_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.empty = (count_reg == 2'd0);
    assign status.full  = (count_reg == 2'd2);

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> count_reg != 2'd2)
        else $error("Queue written while full.");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != 2'd0)
        else $error("Queue read while empty.");

endmodule

// ===== hdl/f2dt_back.sv =====
// ----------------------------------------------------------------------------
// f2dt_back
// Walks the queue head through sign, integer digits, separator and fraction
// digits into the output register, one character per cycle unless stalled.
// ----------------------------------------------------------------------------
module f2dt_back #(
    parameter int FRACTION_DIGITS = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  f2dt_pkg::entry_t     head,
    input  f2dt_pkg::q_status_t  q_status,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [6:0]           m_char_code,
    output logic                 m_last_char
);

    f2dt_pkg::phase_t phase_reg, phase_next, cur_phase;
    logic [2:0] cnt_reg, cnt_next;
    logic       sep_dot_reg;
    logic       m_valid_reg;
    logic [6:0] m_char_code_reg;
    logic       m_last_char_reg;

    logic       load, emit;
    logic [6:0] char_sel;
    logic       last_sel;
    logic [2:0] int_idx;
    logic [2:0] frac_idx3;
    logic [1:0] frac_idx;

    assign cur_phase = (phase_reg == f2dt_pkg::PH_SIGN && !head.neg) ?
                       f2dt_pkg::PH_INT : phase_reg;
    assign load      = !m_valid_reg || m_ready;
    assign emit      = load && !q_status.empty;
    assign int_idx   = head.int_cnt - 3'd1 - cnt_reg;
    assign frac_idx3 = 3'(FRACTION_DIGITS - 1) - cnt_reg;
    assign frac_idx  = frac_idx3[1:0];
    assign pop       = emit && last_sel;

    assign m_valid     = m_valid_reg;
    assign m_char_code = m_char_code_reg;
    assign m_last_char = m_last_char_reg;

    always_comb begin
        char_sel = f2dt_pkg::CH_ZERO;
        last_sel = 1'b0;
        unique case (cur_phase)
            f2dt_pkg::PH_SIGN: char_sel = f2dt_pkg::CH_MINUS;
            f2dt_pkg::PH_INT:  char_sel = f2dt_pkg::CH_ZERO + 7'(head.int_dig[int_idx]);
            f2dt_pkg::PH_SEP:  char_sel = sep_dot_reg ? f2dt_pkg::CH_DOT : f2dt_pkg::CH_COMMA;
            f2dt_pkg::PH_FRAC: begin
                if (head.frac_zero) begin
                    char_sel = f2dt_pkg::CH_ZERO;
                    last_sel = 1'b1;
                end else begin
                    char_sel = f2dt_pkg::CH_ZERO + 7'(head.frac_dig[frac_idx]);
                    last_sel = (cnt_reg == 3'(FRACTION_DIGITS - 1));
                end
            end
            default: char_sel = f2dt_pkg::CH_ZERO;
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        if (emit) begin
            unique case (cur_phase)
                f2dt_pkg::PH_SIGN: begin
                    phase_next = f2dt_pkg::PH_INT;
                    cnt_next   = 3'd0;
                end
                f2dt_pkg::PH_INT: begin
                    if (cnt_reg == head.int_cnt - 3'd1) begin
                        phase_next = f2dt_pkg::PH_SEP;
                        cnt_next   = 3'd0;
                    end else begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                f2dt_pkg::PH_SEP: begin
                    phase_next = f2dt_pkg::PH_FRAC;
                    cnt_next   = 3'd0;
                end
                f2dt_pkg::PH_FRAC: begin
                    if (last_sel) begin
                        phase_next = f2dt_pkg::PH_SIGN;
                        cnt_next   = 3'd0;
                    end else begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                default: begin
                    phase_next = f2dt_pkg::PH_SIGN;
                    cnt_next   = 3'd0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= f2dt_pkg::PH_SIGN;
            cnt_reg     <= 3'd0;
            sep_dot_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            if (cfg_wr_en) sep_dot_reg <= cfg_wr_data;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_char_code_reg <= char_sel;
            m_last_char_reg <= last_sel;
        end
    end

    a_int_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (!q_status.empty && cur_phase == f2dt_pkg::PH_INT) |-> cnt_reg < head.int_cnt)
        else $error("Integer digit index past the significant digits.");

    a_pop_restarts_word: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (phase_reg == f2dt_pkg::PH_SIGN && cnt_reg == 3'd0))
        else $error("Sequencer did not restart after the last word of a value.");

endmodule

// ===== hdl/fixed_to_decimal_text.sv =====
// ----------------------------------------------------------------------------
// fixed_to_decimal_text
// Formats a Q16.16 sign-magnitude value as decimal ASCII text.
// ----------------------------------------------------------------------------
// The input channel (s_*) takes one value per word: a sign flag, a 16-bit
// integer magnitude and a 16-bit binary fraction. The output channel (m_*)
// carries one ASCII character per word; m_last_char marks the final
// character of each value. A value gives 3 to 11 words: an optional minus,
// the integer without leading zeros, the separator, and the fraction digits
// or a single zero.
// The front unit converts a value in five digit steps, each part through its
// own divide-by-ten, then the hand-off, and can take a new value on the
// cycle of the hand-off. A two-entry queue decouples it from the output
// sequencer, which sends one character per cycle unless the receiver stalls.
// The first character is valid in the output register once the value has
// passed the digit steps, the hand-off and the queue.
// When the receiver stalls, the output register holds its word, the queue
// fills, and then s_ready falls. After reset (aresetn low, synchronous) the
// block is empty, ready, and uses a comma as separator; cfg_wr_en writes the
// separator select (1 selects a dot) and should be used while idle.
// ----------------------------------------------------------------------------
module fixed_to_decimal_text #(
    parameter int FRACTION_DIGITS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_is_negative,
    input  logic [15:0] s_integer_part,
    input  logic [15:0] s_fraction_part,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_char_code,
    output logic        m_last_char
);

    logic                push, pop;
    f2dt_pkg::entry_t    push_data, head;
    f2dt_pkg::q_status_t q_status;

    f2dt_front #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_is_negative   (s_is_negative),
        .s_integer_part  (s_integer_part),
        .s_fraction_part (s_fraction_part),
        .q_status        (q_status),
        .push            (push),
        .push_data       (push_data)
    );

    f2dt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    f2dt_back #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last_char (m_last_char)
    );

endmodule
